FILE: rtl/gtass_pkg.sv
// gtass_pkg: types, constants and codes shared by the three-axis sample smoother
// no dependencies
package gtass_pkg;

	localparam int unsigned SMP_W         = 16;
	localparam int unsigned WEIGHT_W      = 17;
	localparam int unsigned CNT_W         = 4;
	localparam int unsigned NUM_AXES      = 3;
	localparam int unsigned NUM_SENS      = 3;
	localparam int unsigned NUM_AVG       = 9;
	localparam int unsigned SLOT_W        = 4;
	localparam int unsigned SENS_W        = 2;
	localparam int unsigned MAX_SAMPLES_DEF = 10;

	localparam logic [WEIGHT_W-1:0] Q16_ONE      = WEIGHT_W'(65536);
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(5898);
	localparam logic signed [SMP_W-1:0] AVG_RESET = SMP_W'(1);

	// per-sensor counter indexes
	localparam logic [SENS_W-1:0] SENS_ACCEL = 2'd0;
	localparam logic [SENS_W-1:0] SENS_GYRO  = 2'd1;
	localparam logic [SENS_W-1:0] SENS_MAG   = 2'd2;

	// first slot of each sensor in the average arrays
	localparam logic [SLOT_W-1:0] GYRO_BASE  = 4'd0;
	localparam logic [SLOT_W-1:0] ACCEL_BASE = 4'd3;
	localparam logic [SLOT_W-1:0] MAG_BASE   = 4'd6;

	typedef enum logic [1:0] {
		MODE_ACCEL = 2'd0,
		MODE_GYRO  = 2'd1,
		MODE_MAG   = 2'd2,
		MODE_TICK  = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t                    mode;
		logic signed [SMP_W-1:0]  sample_x;
		logic signed [SMP_W-1:0]  sample_y;
		logic signed [SMP_W-1:0]  sample_z;
	} sample_t;

	typedef struct packed {
		logic                     no_data_alarm;
		logic signed [SMP_W-1:0]  gyro_x;
		logic signed [SMP_W-1:0]  gyro_y;
		logic signed [SMP_W-1:0]  gyro_z;
		logic signed [SMP_W-1:0]  accel_x;
		logic signed [SMP_W-1:0]  accel_y;
		logic signed [SMP_W-1:0]  accel_z;
		logic signed [SMP_W-1:0]  mag_x;
		logic signed [SMP_W-1:0]  mag_y;
		logic signed [SMP_W-1:0]  mag_z;
	} result_t;

	// one item leaving the input register
	typedef struct packed {
		logic    go;
		sample_t item;
	} step_t;

endpackage

FILE: rtl/gtass_ema.sv
// gtass_ema: one axis of the exponential average, y = trunc((1-w)*s + w*x)
// depends on gtass_pkg
module gtass_ema (
	input  logic [gtass_pkg::WEIGHT_W-1:0]      weight,
	input  logic signed [gtass_pkg::SMP_W-1:0]  avg,
	input  logic signed [gtass_pkg::SMP_W-1:0]  smp,
	output logic signed [gtass_pkg::SMP_W-1:0]  y
);
	import gtass_pkg::*;

	localparam int unsigned DIFF_W = SMP_W + 1;
	localparam int unsigned ACC_W  = DIFF_W + WEIGHT_W + 1;

	logic signed [DIFF_W-1:0]   diff;
	logic signed [WEIGHT_W:0]   w_s;
	logic signed [ACC_W-1:0]    prod;
	logic signed [ACC_W-1:0]    acc;
	logic signed [ACC_W-17:0]   quo;
	logic signed [ACC_W-17:0]   quo_rz;

	// (1-w)*s + w*x rewritten as s*65536 + w*(x-s)
	assign diff = DIFF_W'(smp) - DIFF_W'(avg);
	assign w_s  = $signed({1'b0, weight});
	assign prod = ACC_W'(w_s) * ACC_W'(diff);
	assign acc  = prod + {{(ACC_W-SMP_W-16){avg[SMP_W-1]}}, avg, 16'h0000};

	// round toward zero
	assign quo    = acc[ACC_W-1:16];
	assign quo_rz = (acc[ACC_W-1] && (acc[15:0] != 16'h0000)) ? quo + (ACC_W-16)'(1) : quo;
	assign y      = quo_rz[SMP_W-1:0];

endmodule

FILE: rtl/gtass_state.sv
// gtass_state: averages, held magnetometer reading, period counters and weight
// depends on gtass_pkg and gtass_ema
module gtass_state #(
	parameter int unsigned MAX_SAMPLES = gtass_pkg::MAX_SAMPLES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  gtass_pkg::step_t               step,
	input  logic                           cfg_we,
	input  logic [gtass_pkg::WEIGHT_W-1:0] cfg_weight,
	output gtass_pkg::result_t             next_result
);
	import gtass_pkg::*;

	logic signed [SMP_W-1:0] comm_q [NUM_AVG];
	logic signed [SMP_W-1:0] tent_q [NUM_AVG];
	logic signed [SMP_W-1:0] held_q [NUM_AXES];
	logic [CNT_W-1:0]        cnt_q  [NUM_SENS];
	logic [WEIGHT_W-1:0]     weight_q;

	logic                    is_tick;
	logic [SENS_W-1:0]       sens;
	logic [SLOT_W-1:0]       base;
	logic                    has_room;
	logic                    mag_empty;
	logic                    alarm;
	logic signed [SMP_W-1:0] samp   [NUM_AXES];
	logic signed [SMP_W-1:0] ema_s  [NUM_AXES];
	logic signed [SMP_W-1:0] ema_x  [NUM_AXES];
	logic signed [SMP_W-1:0] ema_y  [NUM_AXES];
	logic signed [SMP_W-1:0] comm_d [NUM_AVG];
	logic [NUM_AVG*SMP_W-1:0] comm_flat;
	logic                    tent_match;

	assign is_tick = (step.item.mode == MODE_TICK);
	assign samp[0] = step.item.sample_x;
	assign samp[1] = step.item.sample_y;
	assign samp[2] = step.item.sample_z;

	always_comb begin
		unique case (step.item.mode)
			MODE_ACCEL: begin
				sens = SENS_ACCEL;
				base = ACCEL_BASE;
			end
			MODE_GYRO: begin
				sens = SENS_GYRO;
				base = GYRO_BASE;
			end
			MODE_MAG, MODE_TICK: begin
				sens = SENS_MAG;
				base = MAG_BASE;
			end
			default: begin
				sens = SENS_MAG;
				base = MAG_BASE;
			end
		endcase
	end

	assign has_room  = (cnt_q[sens] < CNT_W'(MAX_SAMPLES));
	assign mag_empty = (cnt_q[SENS_MAG] == '0);
	assign alarm     = (cnt_q[SENS_ACCEL] == '0) || (cnt_q[SENS_GYRO] == '0);

	// one shared unit per axis: sample update, or held reading on a tick
	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		assign ema_s[a] = tent_q[base + SLOT_W'(a)];
		assign ema_x[a] = is_tick ? held_q[a] : samp[a];

		gtass_ema u_ema (
			.weight (weight_q),
			.avg    (ema_s[a]),
			.smp    (ema_x[a]),
			.y      (ema_y[a])
		);
	end

	always_comb begin
		for (int i = 0; i < NUM_AVG; i++) begin
			comm_d[i] = alarm ? comm_q[i] : tent_q[i];
		end
		if (!alarm && mag_empty) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				comm_d[MAG_BASE + SLOT_W'(a)] = ema_y[a];
			end
		end
	end

	always_comb begin
		next_result.no_data_alarm = alarm;
		next_result.gyro_x  = comm_d[GYRO_BASE + 4'd0];
		next_result.gyro_y  = comm_d[GYRO_BASE + 4'd1];
		next_result.gyro_z  = comm_d[GYRO_BASE + 4'd2];
		next_result.accel_x = comm_d[ACCEL_BASE + 4'd0];
		next_result.accel_y = comm_d[ACCEL_BASE + 4'd1];
		next_result.accel_z = comm_d[ACCEL_BASE + 4'd2];
		next_result.mag_x   = comm_d[MAG_BASE + 4'd0];
		next_result.mag_y   = comm_d[MAG_BASE + 4'd1];
		next_result.mag_z   = comm_d[MAG_BASE + 4'd2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AVG; i++) begin
				comm_q[i] <= AVG_RESET;
				tent_q[i] <= AVG_RESET;
			end
			for (int i = 0; i < NUM_AXES; i++) begin
				held_q[i] <= '0;
			end
			for (int i = 0; i < NUM_SENS; i++) begin
				cnt_q[i] <= '0;
			end
			weight_q <= WEIGHT_RESET;
		end else begin
			if (cfg_we) begin
				weight_q <= (cfg_weight > Q16_ONE) ? Q16_ONE : cfg_weight;
			end
			if (step.go) begin
				if (is_tick) begin
					// after a tick tentative and committed agree either way
					for (int i = 0; i < NUM_AVG; i++) begin
						comm_q[i] <= comm_d[i];
						tent_q[i] <= comm_d[i];
					end
					for (int i = 0; i < NUM_SENS; i++) begin
						cnt_q[i] <= '0;
					end
				end else if (has_room) begin
					cnt_q[sens] <= cnt_q[sens] + CNT_W'(1);
					for (int a = 0; a < NUM_AXES; a++) begin
						tent_q[base + SLOT_W'(a)] <= ema_y[a];
					end
					if (step.item.mode == MODE_MAG) begin
						for (int a = 0; a < NUM_AXES; a++) begin
							held_q[a] <= samp[a];
						end
					end
				end
			end
		end
	end

	always_comb begin
		tent_match = 1'b1;
		for (int i = 0; i < NUM_AVG; i++) begin
			comm_flat[i*SMP_W +: SMP_W] = comm_q[i];
			if (tent_q[i] != comm_q[i]) begin
				tent_match = 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q[0] <= CNT_W'(MAX_SAMPLES)) && (cnt_q[1] <= CNT_W'(MAX_SAMPLES)) &&
		(cnt_q[2] <= CNT_W'(MAX_SAMPLES)))
		else $error("period sample count above limit");

	a_tick_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step.go && is_tick |=> (cnt_q[0] == '0) && (cnt_q[1] == '0) && (cnt_q[2] == '0))
		else $error("tick did not clear sample counts");

	a_tick_sync: assert property (@(posedge clk) disable iff (!arst_n)
		step.go && is_tick |=> tent_match)
		else $error("tentative averages differ from committed after tick");

	a_comm_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(step.go && is_tick) |=> $stable(comm_flat))
		else $error("committed averages changed without tick");

	a_alarm_hold: assert property (@(posedge clk) disable iff (!arst_n)
		step.go && is_tick && alarm |=> $stable(comm_flat))
		else $error("committed averages changed on alarm tick");
`endif

endmodule

FILE: rtl/gated_three_axis_sample_smoother.sv
// gated_three_axis_sample_smoother: one transaction per cycle unless a tick must wait
// for a free result register; each item is one pass through the three
// per-axis multiply-add units between the input register and the result register
// only ticks produce a result; samples update internal state and produce none
// arst_n clears averages to one, held reading and counts to zero, weight to 5898
// depends on gtass_pkg and gtass_state
module gated_three_axis_sample_smoother #(
	parameter int unsigned MAX_SAMPLES = gtass_pkg::MAX_SAMPLES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	output logic                           sample_ready,
	input  gtass_pkg::sample_t             sample,
	output logic                           result_valid,
	input  logic                           result_ready,
	output gtass_pkg::result_t             result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [gtass_pkg::WEIGHT_W-1:0] cfg_data
);
	import gtass_pkg::*;

	logic     valid_s1;
	sample_t  item_s1;
	logic     go_s1;
	logic     tick_s1;
	logic     out_free;
	logic     result_valid_q;
	result_t  result_q;
	result_t  next_result;
	step_t    step;

	assign out_free     = !result_valid_q || result_ready;
	assign tick_s1      = (item_s1.mode == MODE_TICK);
	assign go_s1        = valid_s1 && (!tick_s1 || out_free);
	assign sample_ready = !valid_s1 || go_s1;
	assign cfg_ready    = 1'b1;

	assign step.go   = go_s1;
	assign step.item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			item_s1 <= sample;
		end
	end

	gtass_state #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_state (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_weight  (cfg_data),
		.next_result (next_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= go_s1 && tick_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && tick_s1) begin
			result_q <= next_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
